[rtl/core/mvcc_pkg.sv]
// Shared types and constants of the snapshot visibility check block.
`timescale 1ns / 1ps

package mvcc_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Hint states carried in a tuple header
  typedef enum logic [1:0] {
    HINT_NONE    = 2'd0,
    HINT_COMMIT  = 2'd1,
    HINT_ABORTED = 2'd2,
    HINT_FROZEN  = 2'd3
  } hint_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOW_BOUND  = 2'd0,
    CFG_HIGH_BOUND = 2'd1,
    CFG_OWN_XID    = 2'd2,
    CFG_CMD_ID     = 2'd3
  } cfg_idx_e;

  localparam int unsigned XID_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CMDQ_DEPTH = 2;

  // Input transaction
  typedef struct packed {
    op_e              operation;
    logic [XID_W-1:0] listed_id;
    logic [XID_W-1:0] inserter_id;
    logic [XID_W-1:0] deleter_id;
    logic [XID_W-1:0] tuple_command;
    hint_e            inserter_hint;
    hint_e            deleter_hint;
    logic             updated_flag;
    logic             inserter_did_commit;
    logic             inserter_did_abort;
    logic             deleter_did_commit;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic visible;
    logic mark_inserter_committed;
    logic mark_inserter_invalid;
    logic mark_deleter_committed;
    logic mark_deleter_invalid;
    logic list_overflow;
  } res_t;

  // Comparisons against the snapshot, worked out when an item is accepted
  typedef struct packed {
    logic ins_zero;
    logic ins_lt3;
    logic ins_ge_low;
    logic ins_ge_high;
    logic ins_own;
    logic ins_eq_del;
    logic cid_ge_cmd;
    logic del_zero;
    logic del_lt_low;
    logic del_ge_high;
    logic del_own;
  } flags_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_e              op;
    logic [XID_W-1:0] listed_id;
    logic [XID_W-1:0] inserter_id;
    logic [XID_W-1:0] deleter_id;
    hint_e            inserter_hint;
    hint_e            deleter_hint;
    logic             updated_flag;
    logic             ins_com;
    logic             ins_abt;
    logic             del_com;
    flags_t           flags;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } back_state_e;

endpackage

[rtl/core/mvcc_tuple_visibility_check_top.sv]
// Top level of the snapshot visibility check block.
//
// Usage: the block looks like a queue on both sides. A transaction enters with
// push high while full is low; results leave in order, one per transaction,
// shown while empty is low and taken with pop. Three operations exist: add an
// id to the in-progress list, clear the list, and check a row version.
// Snapshot bounds, own transaction id and command id are written through the
// cfg_we_i / cfg_idx_i / cfg_data_i port; the user must write them only while
// the block is idle, as the block itself does not enforce this.
// Add, clear, the unused code and a check against an empty list pass through
// the idle and done states of the back sequencer; any other check also scans
// the list RAM, read one entry per cycle over the N listed ids, and then drains
// the registered read before done. From push, a transaction first passes the command queue.
// The two-entry command queue keeps taking transactions while a result
// waits; when the result is not popped the back part holds in its final
// step and the queue fills, raising full.
// Reset clears the list count, the queues and the snapshot registers; the
// list memory itself is not cleared.
`timescale 1ns / 1ps

module mvcc_tuple_visibility_check_top import mvcc_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [XID_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  in_t                  in_i,
  output logic                 empty,
  input  logic                 pop,
  output res_t                 res_o
);

  cmd_t cmd_wr, cmd_rd;
  logic q_wr, q_rd, q_full, q_empty;

  mvcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr),
    .cmd_o      (cmd_wr)
  );

  mvcc_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (cmd_wr),
    .rd_i    (q_rd),
    .rdata_o (cmd_rd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mvcc_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .cmd_i     (cmd_rd),
    .q_rd_o    (q_rd),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res_o)
  );

  assign full = q_full;

endmodule

[rtl/core/mvcc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mvcc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mvcc_fifo.sv]
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module mvcc_fifo import mvcc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wdata_i,
  input  logic rd_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/mvcc_front.sv]
// Front part: holds the snapshot registers and classifies accepted transactions.
`timescale 1ns / 1ps

module mvcc_front import mvcc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [XID_W-1:0]     cfg_data_i,
  input  logic                 push_i,
  input  in_t                  in_i,
  input  logic                 q_full_i,
  output logic                 q_wr_o,
  output cmd_t                 cmd_o
);

  logic [XID_W-1:0] low_q, high_q, own_q, cmd_id_q;
  flags_t           flags;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= '0;
      own_q    <= '0;
      cmd_id_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_BOUND:  low_q    <= cfg_data_i;
        CFG_HIGH_BOUND: high_q   <= cfg_data_i;
        CFG_OWN_XID:    own_q    <= cfg_data_i;
        CFG_CMD_ID:     cmd_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Compare ids against the snapshot
  always_comb begin
    flags.ins_zero    = (in_i.inserter_id == '0);
    flags.ins_lt3     = (in_i.inserter_id < XID_W'(3));
    flags.ins_ge_low  = (in_i.inserter_id >= low_q);
    flags.ins_ge_high = (in_i.inserter_id >= high_q);
    flags.ins_own     = (in_i.inserter_id == own_q);
    flags.ins_eq_del  = (in_i.inserter_id == in_i.deleter_id);
    flags.cid_ge_cmd  = (in_i.tuple_command >= cmd_id_q);
    flags.del_zero    = (in_i.deleter_id == '0);
    flags.del_lt_low  = (in_i.deleter_id < low_q);
    flags.del_ge_high = (in_i.deleter_id >= high_q);
    flags.del_own     = (in_i.deleter_id == own_q);
  end

  // Pack the classified command
  always_comb begin
    cmd_o.op            = in_i.operation;
    cmd_o.listed_id     = in_i.listed_id;
    cmd_o.inserter_id   = in_i.inserter_id;
    cmd_o.deleter_id    = in_i.deleter_id;
    cmd_o.inserter_hint = in_i.inserter_hint;
    cmd_o.deleter_hint  = in_i.deleter_hint;
    cmd_o.updated_flag  = in_i.updated_flag;
    cmd_o.ins_com       = in_i.inserter_did_commit;
    cmd_o.ins_abt       = in_i.inserter_did_abort;
    cmd_o.del_com       = in_i.deleter_did_commit;
    cmd_o.flags         = flags;
  end

  assign q_wr_o = push_i && !q_full_i;

endmodule

[rtl/core/mvcc_back.sv]
// Back part: keeps the in-progress list, scans it and forms the result.
`timescale 1ns / 1ps

module mvcc_back import mvcc_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  cmd_t cmd_i,
  output logic q_rd_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             cmp_q;
  logic             found_ins_q, found_del_q;
  logic             out_vld_q, out_vld_d;
  res_t             res_q, res_d;
  logic             out_free;
  logic             rd_en, ram_we, load, res_ld;
  logic [XID_W-1:0] rd_data;

  // Decide visibility and hint bits of a check
  function automatic res_t check_tuple(cmd_t c, logic fi, logic fd);
    res_t   r;
    logic   vis;
    logic   hint;
    flags_t f;
    r    = '0;
    f    = c.flags;
    vis  = 1'b0;
    hint = 1'b0;
    unique case (c.inserter_hint)
      HINT_COMMIT: begin
        if (!f.ins_lt3 && (f.ins_ge_high || (f.ins_ge_low && fi))) return r;
      end
      HINT_ABORTED: begin
        return r;
      end
      HINT_NONE: begin
        if (f.ins_zero) return r;
        if (f.ins_own) begin
          if (f.cid_ge_cmd) return r;
          if (c.updated_flag && f.ins_eq_del) return r;
        end else begin
          priority if (f.ins_lt3) begin
            hint = 1'b1;
            vis  = 1'b1;
          end else if (f.ins_ge_high || (f.ins_ge_low && fi)) begin
            vis = 1'b0;
          end else if (c.ins_com) begin
            hint = 1'b1;
            vis  = 1'b1;
          end else begin
            vis = 1'b0;
          end
          if (hint) begin
            r.mark_inserter_committed = 1'b1;
          end else if (!vis && c.ins_abt) begin
            r.mark_inserter_invalid = 1'b1;
          end
          if (!vis) return r;
        end
      end
      HINT_FROZEN: begin
      end
      default: ;
    endcase

    // Deleter side
    if (f.del_zero) begin
      r.visible = 1'b1;
      return r;
    end
    if (c.deleter_hint == HINT_COMMIT) begin
      r.visible = !f.del_lt_low && (f.del_ge_high || fd);
      return r;
    end
    if (c.deleter_hint != HINT_NONE) begin
      r.visible = 1'b1;
      return r;
    end
    if (f.del_own) begin
      r.visible = f.cid_ge_cmd;
      return r;
    end
    if (f.del_lt_low || !(f.del_ge_high || fd)) begin
      if (c.del_com) begin
        r.mark_deleter_committed = 1'b1;
      end else begin
        r.mark_deleter_invalid = 1'b1;
        r.visible              = 1'b1;
      end
      return r;
    end
    r.visible = 1'b1;
    if (!f.del_ge_high && !c.del_com) begin
      r.mark_deleter_invalid = 1'b1;
    end
    return r;
  endfunction

  assign out_free = !out_vld_q || pop_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (cmd_i.op == OP_CHECK && cnt_q != '0) ? BK_SCAN : BK_DONE;
        end
      end
      BK_SCAN: begin
        if (idx_q + CW'(1) == cnt_q) state_d = BK_DRAIN;
      end
      BK_DRAIN: begin
        state_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_rd_o = 1'b0;
    load   = 1'b0;
    rd_en  = 1'b0;
    res_ld = 1'b0;
    ram_we = 1'b0;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    unique case (state_q)
      BK_IDLE: begin
        q_rd_o = !q_empty_i;
        load   = !q_empty_i;
        idx_d  = '0;
      end
      BK_SCAN: begin
        rd_en = 1'b1;
        idx_d = idx_q + CW'(1);
      end
      BK_DRAIN: ;
      BK_DONE: begin
        if (out_free) begin
          res_ld = 1'b1;
          if (cmd_q.op == OP_ADD && cnt_q < CW'(LIST_DEPTH)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end else if (cmd_q.op == OP_CLEAR) begin
            cnt_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Form the result of the current command
  always_comb begin
    res_d = '0;
    unique case (cmd_q.op)
      OP_ADD:   res_d.list_overflow = (cnt_q >= CW'(LIST_DEPTH));
      OP_CLEAR: ;
      OP_CHECK: res_d = check_tuple(cmd_q, found_ins_q, found_del_q);
      OP_NONE:  ;
      default:  ;
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (pop_i && out_vld_q) out_vld_d = 1'b0;
    if (res_ld) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      cmp_q       <= 1'b0;
      out_vld_q   <= 1'b0;
      found_ins_q <= 1'b0;
      found_del_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      cmp_q     <= rd_en;
      out_vld_q <= out_vld_d;
      // Clear match flags on load, then collect matches from the scan
      if (load) begin
        found_ins_q <= 1'b0;
        found_del_q <= 1'b0;
      end else if (cmp_q) begin
        if (rd_data == cmd_q.inserter_id) found_ins_q <= 1'b1;
        if (rd_data == cmd_q.deleter_id)  found_del_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load)   cmd_q <= cmd_i;
    if (res_ld) res_q <= res_d;
  end

  mvcc_ram #(
    .WIDTH (XID_W),
    .DEPTH (LIST_DEPTH)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (cmd_q.listed_id),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign empty_o = !out_vld_q;
  assign res_o   = res_q;

endmodule

[rtl/core/mvcc_checker.sv]
// Port-level assertions for the snapshot visibility check block, with bind.
`timescale 1ns / 1ps

module mvcc_checker import mvcc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input res_t res_o
);

  logic [3:0] pend_q;

  // Track transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'((push && !full) ? 1 : 0) - 4'((pop && !empty) ? 1 : 0);
    end
  end

  // A waiting result holds until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result changed or vanished while stalled");

  // No result without an accepted transaction behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != 4'd0))
    else $error("result shown with nothing outstanding");

  // An overflowed add carries no check outcome
  a_ovf_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.list_overflow) |->
      (!res_o.visible && !res_o.mark_inserter_committed && !res_o.mark_inserter_invalid
       && !res_o.mark_deleter_committed && !res_o.mark_deleter_invalid))
    else $error("overflow flagged together with check bits");

  // Hint bits of one id never conflict, and a committed delete hides the tuple
  a_hint_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!(res_o.mark_inserter_committed && res_o.mark_inserter_invalid)
                && !(res_o.mark_deleter_committed && res_o.mark_deleter_invalid)
                && !(res_o.mark_deleter_committed && res_o.visible)))
    else $error("conflicting hint bits in result");

endmodule

bind mvcc_tuple_visibility_check_top mvcc_checker u_mvcc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);

[tb/tb.sv]
// Self-checking testbench for the snapshot visibility check block.
`timescale 1ns / 1ps

module tb;
  import mvcc_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;

  // Tracks the snapshot and in-progress list, predicts each result and checks it
  class visibility_scoreboard;
    logic [XID_W-1:0] low_bound;
    logic [XID_W-1:0] high_bound;
    logic [XID_W-1:0] own_xid;
    logic [XID_W-1:0] cmd_id;
    logic [XID_W-1:0] ids [LIST_DEPTH];
    int unsigned      count;
    res_t             expected_q [$];
    int unsigned      errors;
    int unsigned      n_checks;
    int unsigned      n_visible;
    int unsigned      n_overflow;
    int unsigned      n_hints;

    function new();
      low_bound  = '0;
      high_bound = '0;
      own_xid    = '0;
      cmd_id     = '0;
      count      = 0;
      errors     = 0;
      n_checks   = 0;
      n_visible  = 0;
      n_overflow = 0;
      n_hints    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [XID_W-1:0] value);
      case (idx)
        CFG_LOW_BOUND:  low_bound  = value;
        CFG_HIGH_BOUND: high_bound = value;
        CFG_OWN_XID:    own_xid    = value;
        CFG_CMD_ID:     cmd_id     = value;
        default: ;
      endcase
    endfunction

    function bit is_listed(logic [XID_W-1:0] id);
      for (int unsigned i = 0; i < count; i++) begin
        if (ids[i] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit in_snapshot(logic [XID_W-1:0] id);
      if (id >= high_bound) return 1'b1;
      if (id < low_bound) return 1'b0;
      return is_listed(id);
    endfunction

    // Decide visibility of one row version; hint bits are set in r on the way
    function bit row_visible(in_t t, inout res_t r);
      logic [XID_W-1:0] ins;
      logic [XID_W-1:0] del;
      bit               vis;
      bit               hint;
      ins = t.inserter_id;
      del = t.deleter_id;

      // Inserter side
      if (t.inserter_hint == HINT_COMMIT) begin
        if (ins >= 3 && in_snapshot(ins)) return 1'b0;
      end else if (t.inserter_hint == HINT_ABORTED) begin
        return 1'b0;
      end else if (t.inserter_hint == HINT_NONE) begin
        if (ins == '0) return 1'b0;
        if (ins == own_xid) begin
          if (t.tuple_command >= cmd_id) return 1'b0;
          if (t.updated_flag && ins == del) return 1'b0;
        end else begin
          hint = 1'b0;
          vis  = 1'b0;
          if (ins < 3) begin
            hint = 1'b1;
            vis  = 1'b1;
          end else if (ins >= high_bound || (ins >= low_bound && is_listed(ins))) begin
            vis = 1'b0;
          end else if (t.inserter_did_commit) begin
            hint = 1'b1;
            vis  = 1'b1;
          end
          if (hint) r.mark_inserter_committed = 1'b1;
          else if (!vis && t.inserter_did_abort) r.mark_inserter_invalid = 1'b1;
          if (!vis) return 1'b0;
        end
      end

      // Deleter side
      if (del == '0) return 1'b1;
      if (t.deleter_hint == HINT_COMMIT) begin
        if (del < low_bound) return 1'b0;
        if (del >= high_bound) return 1'b1;
        return is_listed(del);
      end
      if (t.deleter_hint != HINT_NONE) return 1'b1;
      if (del == own_xid) return t.tuple_command >= cmd_id;
      if (del < low_bound || !(del >= high_bound || is_listed(del))) begin
        if (t.deleter_did_commit) begin
          r.mark_deleter_committed = 1'b1;
          return 1'b0;
        end
        r.mark_deleter_invalid = 1'b1;
        return 1'b1;
      end
      if (del >= high_bound) return 1'b1;
      if (!t.deleter_did_commit) r.mark_deleter_invalid = 1'b1;
      return 1'b1;
    endfunction

    // Note an accepted transaction and queue the result it should produce
    function void note_input(in_t t);
      res_t r;
      bit   vis;
      r = '0;
      case (t.operation)
        OP_ADD: begin
          if (count < LIST_DEPTH) begin
            ids[count] = t.listed_id;
            count++;
          end else begin
            r.list_overflow = 1'b1;
            n_overflow++;
          end
        end
        OP_CLEAR: count = 0;
        OP_CHECK: begin
          vis = row_visible(t, r);
          r.visible = vis;
          n_checks++;
          if (vis) n_visible++;
        end
        default: ;
      endcase
      if (r.mark_inserter_committed || r.mark_inserter_invalid ||
          r.mark_deleter_committed || r.mark_deleter_invalid) n_hints++;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic exp_bit, logic act_bit);
      if (act_bit !== exp_bit) begin
        errors++;
        $error("%s: expected %0b, got %0b", name, exp_bit, act_bit);
      end
    endfunction

    // Compare a popped result with the oldest expectation
    function void check_result(res_t r);
      res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with nothing expected: %p", r);
        return;
      end
      e = expected_q.pop_front();
      check_field("visible", e.visible, r.visible);
      check_field("mark_inserter_committed", e.mark_inserter_committed,
                  r.mark_inserter_committed);
      check_field("mark_inserter_invalid", e.mark_inserter_invalid,
                  r.mark_inserter_invalid);
      check_field("mark_deleter_committed", e.mark_deleter_committed,
                  r.mark_deleter_committed);
      check_field("mark_deleter_invalid", e.mark_deleter_invalid,
                  r.mark_deleter_invalid);
      check_field("list_overflow", e.list_overflow, r.list_overflow);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [XID_W-1:0]     cfg_data_i = '0;
  logic                 push       = 1'b0;
  logic                 full;
  in_t                  in_i       = '0;
  logic                 empty;
  logic                 pop        = 1'b0;
  res_t                 res_o;

  visibility_scoreboard sb;
  bit                   quiet         = 1'b0;
  int unsigned          send_gap_pct  = 0;
  int unsigned          pop_stall_pct = 0;
  int unsigned          n_sent        = 0;
  int unsigned          n_settings    = 0;

  mvcc_tuple_visibility_check_top #(
    .LIST_DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push      (push),
    .full      (full),
    .in_i      (in_i),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Check every result taken from the block
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(res_o);
  end

  // Receiver: take results, stalling in random bursts
  initial begin
    @(posedge clk_i);
    forever begin
      if (!quiet && pop_stall_pct != 0 && $urandom_range(0, 99) < pop_stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Fully random transaction, the base of every other one
  function automatic in_t noise_item();
    logic [159:0] raw;
    in_t          t;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(in_t)-1:0];
    return t;
  endfunction

  function automatic in_t op_item(op_e op, logic [XID_W-1:0] id);
    in_t t;
    t = noise_item();
    t.operation = op;
    t.listed_id = id;
    return t;
  endfunction

  function automatic in_t row(logic [XID_W-1:0] ins, logic [XID_W-1:0] del,
                              logic [XID_W-1:0] cid, hint_e ih, hint_e dh,
                              bit upd, bit icom, bit iab, bit dcom);
    in_t t;
    t = noise_item();
    t.operation           = OP_CHECK;
    t.inserter_id         = ins;
    t.deleter_id          = del;
    t.tuple_command       = cid;
    t.inserter_hint       = ih;
    t.deleter_hint        = dh;
    t.updated_flag        = upd;
    t.inserter_did_commit = icom;
    t.inserter_did_abort  = iab;
    t.deleter_did_commit  = dcom;
    return t;
  endfunction

  // Id inside the snapshot window [low, high), or any id when the window is empty or inverted
  function automatic logic [XID_W-1:0] in_window();
    if (sb.low_bound < sb.high_bound)
      return sb.low_bound + $urandom_range(0, sb.high_bound - sb.low_bound - 1);
    return $urandom;
  endfunction

  // Id drawn from the boundaries that steer the decision
  function automatic logic [XID_W-1:0] pick_xid();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return $urandom_range(1, 2);
      2: return sb.low_bound - 1;
      3: return sb.low_bound;
      4: return (sb.count != 0) ? sb.ids[$urandom_range(0, sb.count - 1)] : $urandom;
      5: return sb.high_bound - 1;
      6: return sb.high_bound;
      7: return sb.own_xid;
      8: return $urandom;
      default: return in_window();
    endcase
  endfunction

  function automatic logic [XID_W-1:0] pick_cid();
    case ($urandom_range(0, 5))
      0: return sb.cmd_id - 1;
      1: return sb.cmd_id;
      2: return sb.cmd_id + 1;
      3: return '0;
      4: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_check();
    in_t t;
    t = row(pick_xid(), ($urandom_range(0, 3) == 0) ? '0 : pick_xid(), pick_cid(),
            $urandom_range(0, 1) ? HINT_NONE : hint_e'($urandom_range(0, 3)),
            $urandom_range(0, 1) ? HINT_NONE : hint_e'($urandom_range(0, 3)),
            $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
            $urandom_range(0, 1));
    // Self-updated rows need the deleter to match the inserter
    if ($urandom_range(0, 7) == 0) t.deleter_id = t.inserter_id;
    return t;
  endfunction

  // Offer one transaction and hold it until the block takes it
  task automatic send(in_t t);
    push <= 1'b1;
    in_i <= t;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
    sb.note_input(t);
    n_sent++;
    if (!quiet && send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every expected result has been taken
  task automatic wait_drained(int unsigned settle);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write all four snapshot registers back to back
  task automatic set_snapshot(logic [XID_W-1:0] lo, logic [XID_W-1:0] hi,
                              logic [XID_W-1:0] own, logic [XID_W-1:0] cmd);
    logic [XID_W-1:0] vals [4];
    vals = '{lo, hi, own, cmd};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("[mvcc_tuple_visibility_check_top] ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    logic [XID_W-1:0] lo;
    logic [XID_W-1:0] hi;
    int unsigned      n_ids;
    int unsigned      phase;
    int unsigned      k;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset snapshot: every id sits at or above the high bound
    send(row(32'd5, 32'd0, 32'd0, HINT_NONE, HINT_NONE, 1'b0, 1'b1, 1'b0, 1'b0));
    wait_drained(4);
    set_snapshot(32'd100, 32'd200, 32'd150, 32'd10);
    send(op_item(OP_ADD, 32'd120));
    send(op_item(OP_ADD, 32'd150));
    send(op_item(OP_ADD, 32'd180));
    // Invalid inserter, then the special ids
    send(row(32'd0, 32'd0, 32'd0, HINT_NONE, HINT_NONE, 1'b0, 1'b1, 1'b0, 1'b0));
    send(row(32'd1, 32'd0, 32'd0, HINT_NONE, HINT_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    send(row(32'd2, 32'd300, 32'd0, HINT_NONE, HINT_NONE, 1'b0, 1'b0, 1'b0, 1'b1));
    // Committed hint but inside the snapshot; aborted hint
    send(row(32'd120, 32'd0, 32'd0, HINT_COMMIT, HINT_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    send(row(32'd250, 32'd0, 32'd0, HINT_COMMIT, HINT_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    send(row(32'd130, 32'd0, 32'd0, HINT_ABORTED, HINT_NONE, 1'b0, 1'b1, 1'b0, 1'b0));
    // Own inserter: the current command, then updated by itself
    send(row(32'd150, 32'd0, 32'd10, HINT_NONE, HINT_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    send(row(32'd150, 32'd150, 32'd3, HINT_NONE, HINT_NONE, 1'b1, 1'b0, 1'b0, 1'b0));
    // Own deleter, ignored for a later command
    send(row(32'd50, 32'd150, 32'd20, HINT_NONE, HINT_NONE, 1'b0, 1'b1, 1'b0, 1'b0));
    send(row(32'd50, 32'd150, 32'd5, HINT_NONE, HINT_NONE, 1'b0, 1'b1, 1'b0, 1'b0));
    // Deleter hints and commit-log answers
    send(row(32'd50, 32'd60, 32'd0, HINT_FROZEN, HINT_FROZEN, 1'b0, 1'b0, 1'b0, 1'b1));
    send(row(32'd50, 32'd60, 32'd0, HINT_NONE, HINT_COMMIT, 1'b0, 1'b1, 1'b0, 1'b0));
    send(row(32'd50, 32'd60, 32'd0, HINT_NONE, HINT_NONE, 1'b0, 1'b1, 1'b0, 1'b1));
    send(row(32'd50, 32'd60, 32'd0, HINT_NONE, HINT_NONE, 1'b0, 1'b1, 1'b0, 1'b0));
    send(row(32'd50, 32'd120, 32'd0, HINT_NONE, HINT_NONE, 1'b0, 1'b1, 1'b0, 1'b0));
    send(row(32'd130, 32'd0, 32'd0, HINT_NONE, HINT_NONE, 1'b0, 1'b0, 1'b1, 1'b0));
    send(row(32'd130, 32'd0, 32'd0, HINT_FROZEN, HINT_NONE, 1'b0, 1'b0, 1'b1, 1'b0));
    send(op_item(OP_NONE, 32'd0));
    send(row('1, '1, '1, HINT_NONE, HINT_COMMIT, 1'b1, 1'b1, 1'b1, 1'b1));
    send(op_item(OP_ADD, '1));
    send(op_item(OP_CLEAR, '1));

    // Random phases, each under its own snapshot setting
    phase = 0;
    while (n_sent < 750) begin
      wait_drained(4);
      if (n_sent >= 650) quiet = 1'b1;
      send_gap_pct  = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 8 : 25);
      pop_stall_pct = (phase % 4 == 3) ? 0 : 10 + 10 * (phase % 4);
      case (phase % 6)
        0: set_snapshot('0, '1, '1, '1);
        1: set_snapshot('0, '0, '0, '0);
        2: begin
          // Inverted bounds
          lo = $urandom_range(3000, 32'hFFFF_0000);
          hi = lo - $urandom_range(1, 2000);
          set_snapshot(lo, hi, lo - $urandom_range(0, 3000), $urandom_range(0, 50));
        end
        default: begin
          lo = $urandom_range(3, 32'hFFFF_0000);
          hi = lo + $urandom_range(1, 3000);
          set_snapshot(lo, hi,
                       ($urandom_range(0, 3) == 0) ? $urandom : lo + $urandom_range(0, hi - lo),
                       ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1, 50));
        end
      endcase

      // Rebuild the in-progress list, now and then past its capacity
      send(op_item(OP_CLEAR, $urandom));
      n_ids = ($urandom_range(0, 5) == 0) ? LIST_DEPTH + $urandom_range(1, 3)
                                          : $urandom_range(0, 16);
      repeat (n_ids)
        send(op_item(OP_ADD, ($urandom_range(0, 9) == 0) ? $urandom : in_window()));

      // Mostly row checks, with some noise mixed in
      repeat ($urandom_range(30, 60)) begin
        k = $urandom_range(0, 19);
        if (k == 0) send(noise_item());
        else if (k == 1) send(op_item(OP_ADD, pick_xid()));
        else if (k == 2) send(op_item(OP_NONE, $urandom));
        else send(random_check());
      end
      phase++;
    end

    // Drain and let the last scan finish
    quiet = 1'b1;
    wait_drained(80);
    $display("Covered %0d transactions under %0d snapshot settings: %0d row checks (%0d visible),",
             n_sent, n_settings, sb.n_checks, sb.n_visible);
    $display("  %0d results asking for hint bits and %0d adds dropped on a full list",
             sb.n_hints, sb.n_overflow);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[mvcc_tuple_visibility_check_top] OK");
    end else begin
      $display("[mvcc_tuple_visibility_check_top] ERROR");
    end
    $finish;
  end

endmodule
